>>> hw/rtl/efr_pkg.sv
// Package for the escaped frame receiver: result kinds, register indexes,
// result struct and configuration defaults. No dependencies.
package efr_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned CfgIdxW = 2;

	localparam logic [ByteW-1:0] StartReset = 8'd126;
	localparam logic [ByteW-1:0] EscapeReset = 8'd125;
	localparam logic [ByteW-1:0] MaskReset = 8'd32;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_GOOD = 2'd1,
		KIND_BAD = 2'd2
	} kind_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_START = 2'd0,
		REG_ESCAPE = 2'd1,
		REG_MASK = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [ByteW-1:0] start_value;
		logic [ByteW-1:0] escape_value;
		logic [ByteW-1:0] escape_mask;
	} cfg_t;

	typedef struct packed {
		kind_t kind;
		logic [ByteW-1:0] data_byte;
		logic [ByteW-1:0] byte_index;
	} res_t;

endpackage

>>> hw/rtl/efr_if.sv
// Channel interfaces of the escaped frame receiver: raw byte in, result out.
// Depends on efr_pkg.
interface efr_in_if;
	import efr_pkg::*;
	logic valid;
	logic ready;
	logic [ByteW-1:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface efr_out_if;
	import efr_pkg::*;
	logic valid;
	logic ready;
	kind_t kind;
	logic [ByteW-1:0] data_byte;
	logic [ByteW-1:0] byte_index;
	modport source (output valid, output kind, output data_byte, output byte_index,
		input ready);
	modport sink (input valid, input kind, input data_byte, input byte_index,
		output ready);
endinterface

>>> hw/rtl/efr_cfg.sv
// Configuration registers of the escaped frame receiver.
// Depends on efr_pkg.
module efr_cfg (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [efr_pkg::CfgIdxW-1:0] cfg_index,
	input logic [efr_pkg::ByteW-1:0] cfg_data,
	output efr_pkg::cfg_t cfg
);
	import efr_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_value <= StartReset;
			cfg_q.escape_value <= EscapeReset;
			cfg_q.escape_mask <= MaskReset;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_START: cfg_q.start_value <= cfg_data;
				REG_ESCAPE: cfg_q.escape_value <= cfg_data;
				REG_MASK: cfg_q.escape_mask <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> hw/rtl/efr_parse.sv
// Input register and frame parser: unescape, length, payload index, checksum.
// Depends on efr_pkg and efr_if.
module efr_parse (
	input logic clk,
	input logic arst_n,
	efr_in_if.sink rx,
	input efr_pkg::cfg_t cfg,
	input logic advance,
	output logic res_valid,
	output efr_pkg::res_t res
);
	import efr_pkg::*;

	logic s1_valid_s1;
	logic [ByteW-1:0] byte_s1;

	logic after_start_q;
	logic after_escape_q;
	logic idle_q;
	logic [ByteW-1:0] left_q;
	logic [ByteW-1:0] sum_q;
	logic [ByteW-1:0] pos_q;

	logic take;
	logic is_start;
	logic ignore;
	logic is_escape;
	logic [ByteW-1:0] unesc;
	logic [ByteW-1:0] new_sum;

	assign rx.ready = !s1_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			s1_valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	always_comb begin
		take = s1_valid_s1 && advance;
		is_start = byte_s1 == cfg.start_value;
		ignore = !after_start_q && idle_q;
		is_escape = !after_escape_q && (byte_s1 == cfg.escape_value);
		unesc = after_escape_q ? (byte_s1 ^ cfg.escape_mask) : byte_s1;
		new_sum = sum_q + unesc;
		res_valid = s1_valid_s1 && !is_start && !ignore && !is_escape && !after_start_q;
		res.data_byte = '0;
		res.byte_index = pos_q;
		if (left_q != '0) begin
			res.kind = KIND_PAYLOAD;
			res.data_byte = unesc;
		end else if (new_sum == '0) begin
			res.kind = KIND_GOOD;
		end else begin
			res.kind = KIND_BAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			after_start_q <= 1'b0;
			after_escape_q <= 1'b0;
			idle_q <= 1'b1;
			left_q <= '0;
			sum_q <= '0;
			pos_q <= '0;
		end else if (take) begin
			if (is_start) begin
				after_start_q <= 1'b1;
				after_escape_q <= 1'b0;
			end else if (!ignore) begin
				if (is_escape) begin
					after_escape_q <= 1'b1;
				end else begin
					after_escape_q <= 1'b0;
					if (after_start_q) begin
						after_start_q <= 1'b0;
						idle_q <= 1'b0;
						left_q <= unesc;
						sum_q <= '0;
						pos_q <= '0;
					end else begin
						sum_q <= new_sum;
						if (left_q != '0) begin
							left_q <= left_q - 1'b1;
							pos_q <= pos_q + 1'b1;
						end else begin
							idle_q <= 1'b1;
						end
					end
				end
			end
		end
	end

endmodule

>>> hw/rtl/efr_out.sv
// Result register of the escaped frame receiver; holds an item until taken.
// Depends on efr_pkg and efr_if.
module efr_out (
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input efr_pkg::res_t res,
	output logic advance,
	efr_out_if.source res_ch
);
	import efr_pkg::*;

	logic valid_q;
	res_t res_q;

	assign advance = !valid_q || res_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_q <= res;
		end
	end

	assign res_ch.valid = valid_q;
	assign res_ch.kind = res_q.kind;
	assign res_ch.data_byte = res_q.data_byte;
	assign res_ch.byte_index = res_q.byte_index;

endmodule

>>> hw/rtl/escaped_frame_receiver.sv
// Top level of the escaped frame receiver: config registers, parser, result register.
// Depends on efr_pkg, efr_if, efr_cfg, efr_parse, efr_out.
//
//  channel  | dir | payload                         | handshake
//  rx       | in  | rx_byte[7:0]                    | valid/ready
//  res      | out | kind[1:0] data_byte byte_index  | valid/ready
//  cfg      | in  | cfg_index[1:0] cfg_data[7:0]    | cfg_we, no ready
//
// One byte per cycle sustained while res is not stalled; a result is valid once its byte has been taken.
// Each byte passes the input register, then the parser logic into the result register.
// A stall on res holds the result register and, through advance, the input register.
// Reset clears valids and frame state; configuration returns to its defaults.
module escaped_frame_receiver (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [efr_pkg::CfgIdxW-1:0] cfg_index,
	input logic [efr_pkg::ByteW-1:0] cfg_data,
	efr_in_if.sink rx,
	efr_out_if.source res
);
	import efr_pkg::*;

	cfg_t cfg;
	logic advance;
	logic res_valid;
	res_t res_d;

	efr_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	efr_parse u_parse (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx),
		.cfg(cfg),
		.advance(advance),
		.res_valid(res_valid),
		.res(res_d)
	);

	efr_out u_out (
		.clk(clk),
		.arst_n(arst_n),
		.res_valid(res_valid),
		.res(res_d),
		.advance(advance),
		.res_ch(res)
	);

endmodule
